// ----- rtl/nwed_pkg.sv -----
// Shared types, constants and helpers for the nearest-word edit distance block.
`default_nettype none

package nwed_pkg;

	localparam int MAX_QUERY_LEN = 32;
	localparam int MAX_WORDS = 65536;

	localparam int QIDX_W = ($clog2(MAX_QUERY_LEN) > 0) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int QLEN_W = $clog2(MAX_QUERY_LEN + 1);
	localparam int WCNT_W = $clog2(MAX_WORDS);

	localparam logic [QLEN_W-1:0] QLEN_MAX = QLEN_W'(MAX_QUERY_LEN);

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CHAR  = 2'd2,
		CMD_EMPTY = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] character;
		logic       last_char;
		logic       last_word;
	} req_t;

	typedef struct packed {
		logic [15:0] word_index;
		logic [7:0]  distance;
		logic        rejected;
		logic        skipped;
		logic [15:0] best_index;
		logic [7:0]  best_distance;
		logic        best_valid;
		logic        search_done;
	} res_t;

	// one row update travelling down the cell chain
	typedef struct packed {
		logic       vld;
		logic       upd;
		logic       first;
		logic [7:0] ch;
		logic [7:0] diag;
		logic [7:0] left;
		logic [7:0] tail;
		logic       hit;
	} wave_t;

	typedef struct packed {
		logic              en;
		logic [QIDX_W-1:0] addr;
		logic [7:0]        ch;
	} qwr_t;

	function automatic logic [7:0] sat8(input logic [8:0] v);
		return (v > 9'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [QIDX_W-1:0] to_pos(input int i);
		return i[QIDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/nwed_cell.sv -----
// One cell of the edit distance row: a query character and one row value.
`default_nettype none

module nwed_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [nwed_pkg::QIDX_W-1:0]  pos,
	input  wire logic [nwed_pkg::QLEN_W-1:0]  qlen,
	input  wire logic [7:0]                   row_num,
	input  wire nwed_pkg::qwr_t               qwr,
	input  wire nwed_pkg::wave_t              wave_i,
	output nwed_pkg::wave_t                   wave_o
);

	logic [7:0]      q_q;
	logic [7:0]      val_q;
	logic            vld_q;
	nwed_pkg::wave_t wave_q;

	logic [7:0] init_val;
	logic [7:0] old_val;
	logic [8:0] cost;
	logic [8:0] from_left;
	logic [8:0] from_up;
	logic [8:0] from_diag;
	logic [8:0] best;
	logic [7:0] new_val;
	logic       at_tail;
	logic       hit_here;

	always_comb begin
		init_val  = nwed_pkg::sat8(9'(pos) + 9'd1);
		old_val   = wave_i.first ? init_val : val_q;
		cost      = (q_q == wave_i.ch) ? 9'd0 : 9'd1;
		from_left = 9'(wave_i.left) + 9'd1;
		from_up   = 9'(old_val) + 9'd1;
		from_diag = 9'(wave_i.diag) + cost;
		best      = from_left;
		if (from_up < best) begin
			best = from_up;
		end
		if (from_diag < best) begin
			best = from_diag;
		end
		new_val  = nwed_pkg::sat8(best);
		at_tail  = (9'(pos) + 9'd1) == 9'(qlen);
		// this cell holds the query char at the word's current position
		hit_here = (9'(row_num) == 9'(pos)) && (9'(pos) < 9'(qlen)) &&
			(row_num != 8'hFF) && (q_q == wave_i.ch);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= wave_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (qwr.en && (qwr.addr == pos)) begin
			q_q <= qwr.ch;
		end
		if (wave_i.vld) begin
			wave_q.vld   <= 1'b1;
			wave_q.upd   <= wave_i.upd;
			wave_q.first <= wave_i.first;
			wave_q.ch    <= wave_i.ch;
			wave_q.diag  <= old_val;
			wave_q.left  <= new_val;
			wave_q.tail  <= at_tail ? new_val : wave_i.tail;
			wave_q.hit   <= wave_i.hit | hit_here;
			if (wave_i.upd) begin
				val_q <= new_val;
			end
		end
	end

	always_comb begin
		wave_o     = wave_q;
		wave_o.vld = vld_q;
	end

endmodule

`default_nettype wire

// ----- rtl/nwed_row.sv -----
// Chain of edit distance cells, one per query position.
`default_nettype none

module nwed_row (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [nwed_pkg::QLEN_W-1:0]  qlen,
	input  wire logic [7:0]                   row_num,
	input  wire nwed_pkg::qwr_t               qwr,
	input  wire nwed_pkg::wave_t              wave_i,
	output nwed_pkg::wave_t                   wave_o
);

	nwed_pkg::wave_t link [0:nwed_pkg::MAX_QUERY_LEN];

	assign link[0] = wave_i;

	for (genvar g = 0; g < nwed_pkg::MAX_QUERY_LEN; g++) begin : g_cell
		nwed_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pos     (nwed_pkg::to_pos(g)),
			.qlen    (qlen),
			.row_num (row_num),
			.qwr     (qwr),
			.wave_i  (link[g]),
			.wave_o  (link[g+1])
		);
	end

	assign wave_o = link[nwed_pkg::MAX_QUERY_LEN];

endmodule

`default_nettype wire

// ----- rtl/nearest_word_edit_distance.sv -----
// Top level of the nearest-word edit distance search.
// Start and query commands leave busy low; an empty-word command goes to the
// finish state. A candidate character keeps busy high while its row update
// ripples through the chain of cells, one cell per cycle, unless an exact match
// was found before. A word end passes the finish state, then the result is shown
// on result for exactly one cycle with result_valid high; the receiver cannot
// stall it, so it must be captured then. The threshold port always accepts.
`default_nettype none

module nearest_word_edit_distance (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire nwed_pkg::req_t  request,
	output logic                 result_valid,
	output nwed_pkg::res_t       result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [7:0]      cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WAVE   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                        state_q;
	logic [nwed_pkg::QLEN_W-1:0]   qlen_q;
	logic [7:0]                    row_num_q;
	logic                          still_eq_q;
	logic                          word_rej_q;
	logic [nwed_pkg::WCNT_W-1:0]   wcnt_q;
	logic [nwed_pkg::WCNT_W-1:0]   best_word_q;
	logic [7:0]                    best_score_q;
	logic                          have_best_q;
	logic                          exact_q;
	logic [7:0]                    cutoff_q;
	logic                          lastc_q;
	logic                          lastw_q;
	logic [7:0]                    tail_q;
	logic                          result_valid_q;
	nwed_pkg::res_t                result_q;

	logic            accept;
	nwed_pkg::qwr_t  qwr;
	nwed_pkg::wave_t wave_in;
	nwed_pkg::wave_t wave_out;

	logic        fin_skip;
	logic        fin_rej;
	logic [7:0]  fin_d;
	logic        fin_take;
	logic        fin_exact;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		qwr.en   = accept && (request.command == nwed_pkg::CMD_QUERY) &&
			(qlen_q < nwed_pkg::QLEN_MAX);
		qwr.addr = qlen_q[nwed_pkg::QIDX_W-1:0];
		qwr.ch   = request.character;

		wave_in.vld   = accept && (request.command == nwed_pkg::CMD_CHAR) && !exact_q;
		wave_in.upd   = !word_rej_q;
		wave_in.first = (row_num_q == 8'd0);
		wave_in.ch    = request.character;
		wave_in.diag  = row_num_q;
		wave_in.left  = nwed_pkg::sat8(9'(row_num_q) + 9'd1);
		wave_in.tail  = wave_in.left;
		wave_in.hit   = 1'b0;
	end

	nwed_row u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.qlen    (qlen_q),
		.row_num (row_num_q),
		.qwr     (qwr),
		.wave_i  (wave_in),
		.wave_o  (wave_out)
	);

	// scoring of the word that just ended
	always_comb begin
		fin_skip = exact_q;
		fin_rej  = 1'b0;
		fin_d    = 8'd0;
		if (fin_skip) begin
			fin_d = 8'd0;
		end else if (still_eq_q && (9'(row_num_q) == 9'(qlen_q))) begin
			fin_d = 8'd0;
		end else if (qlen_q == '0) begin
			fin_d = row_num_q;
		end else if (row_num_q == 8'd0) begin
			fin_d = nwed_pkg::sat8(9'(qlen_q));
		end else if (word_rej_q) begin
			fin_rej = 1'b1;
			fin_d   = 8'd255;
		end else begin
			fin_d = tail_q;
		end
		fin_take  = !fin_skip && !fin_rej && (!have_best_q || (fin_d <= best_score_q));
		fin_exact = exact_q || (!fin_skip && !fin_rej && (fin_d == 8'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			qlen_q         <= '0;
			row_num_q      <= 8'd0;
			still_eq_q     <= 1'b1;
			word_rej_q     <= 1'b0;
			wcnt_q         <= '0;
			best_word_q    <= '0;
			best_score_q   <= 8'd0;
			have_best_q    <= 1'b0;
			exact_q        <= 1'b0;
			cutoff_q       <= 8'd255;
			lastc_q        <= 1'b0;
			lastw_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cutoff_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lastc_q <= request.last_char;
						lastw_q <= request.last_word;
						case (request.command)
							nwed_pkg::CMD_START: begin
								qlen_q       <= '0;
								row_num_q    <= 8'd0;
								still_eq_q   <= 1'b1;
								word_rej_q   <= 1'b0;
								wcnt_q       <= '0;
								best_word_q  <= '0;
								best_score_q <= 8'd0;
								have_best_q  <= 1'b0;
								exact_q      <= 1'b0;
							end
							nwed_pkg::CMD_QUERY: begin
								if (qwr.en) begin
									qlen_q <= qlen_q + nwed_pkg::QLEN_W'(1);
								end
								row_num_q  <= 8'd0;
								still_eq_q <= 1'b1;
								word_rej_q <= 1'b0;
							end
							nwed_pkg::CMD_CHAR: begin
								if (!exact_q) begin
									state_q <= ST_WAVE;
								end else if (request.last_char) begin
									state_q <= ST_FINISH;
								end
							end
							nwed_pkg::CMD_EMPTY: begin
								row_num_q  <= 8'd0;
								still_eq_q <= 1'b1;
								word_rej_q <= 1'b0;
								state_q    <= ST_FINISH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WAVE: begin
					if (wave_out.vld) begin
						still_eq_q <= still_eq_q && wave_out.hit;
						if (wave_out.upd && (wave_out.tail > cutoff_q)) begin
							word_rej_q <= 1'b1;
						end
						if (row_num_q != 8'hFF) begin
							row_num_q <= row_num_q + 8'd1;
						end
						state_q <= lastc_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (fin_take) begin
						best_word_q  <= wcnt_q;
						best_score_q <= fin_d;
						have_best_q  <= 1'b1;
					end
					exact_q        <= fin_exact;
					wcnt_q         <= wcnt_q + nwed_pkg::WCNT_W'(1);
					row_num_q      <= 8'd0;
					still_eq_q     <= 1'b1;
					word_rej_q     <= 1'b0;
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WAVE) && wave_out.vld && wave_out.upd) begin
			tail_q <= wave_out.tail;
		end
		if (state_q == ST_FINISH) begin
			result_q.word_index    <= 16'(wcnt_q);
			result_q.distance      <= fin_d;
			result_q.rejected      <= fin_rej;
			result_q.skipped       <= fin_skip;
			result_q.best_index    <= fin_take ? 16'(wcnt_q) : 16'(best_word_q);
			result_q.best_distance <= fin_take ? fin_d : best_score_q;
			result_q.best_valid    <= have_best_q || fin_take;
			result_q.search_done   <= lastw_q || fin_exact;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- rtl/nwed_checker.sv -----
// Port-level checks for the nearest-word edit distance block, bound to the top.
`default_nettype none

module nwed_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire nwed_pkg::req_t request,
	input wire logic           result_valid,
	input wire nwed_pkg::res_t result
);

	// a result only follows a busy cycle
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without preceding busy cycle");

	a_res_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// start and query items leave busy low and make no result
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((request.command == nwed_pkg::CMD_START) ||
			(request.command == nwed_pkg::CMD_QUERY))) |=> (!busy && !result_valid))
		else $error("start or query item did not complete at once");

	a_skip_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.skipped) |-> ((result.distance == 8'd0) && !result.rejected))
		else $error("skipped item carries a distance");

	a_rej_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.rejected) |-> (result.distance == 8'd255))
		else $error("rejected item without saturated distance");

endmodule

bind nearest_word_edit_distance nwed_checker u_nwed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.request      (request),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
